// ===== hw/rtl/hsec_pkg.sv =====
// ---------------------------------------------------------------------------
// hsec_pkg
// Shared constants and helper functions for the Hamming SEC encoder/decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package hsec_pkg;

    // fixed field widths
    localparam int CODE_W = 63;
    localparam int DATA_W = 57;
    localparam int SYN_W  = 6;
    localparam int CFG_W  = 6;

    // longest codeword the block handles
    localparam int MAX_CODE_BITS = 63;

    // action codes
    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    // data_bits after reset
    localparam logic [CFG_W-1:0] DATA_BITS_RESET = 6'd4;

    // smallest r with 2^r >= m + r + 1
    function automatic int parity_count(input int m);
        int r;
        r = 0;
        for (int i = 0; i < 8; i++)
        begin
            if ((1 << r) < m + r + 1)
                r = r + 1;
        end
        return r;
    endfunction

    // largest m whose code length still fits
    function automatic int max_data_bits(input int max_n);
        int best;
        best = 1;
        for (int m = 1; m < 64; m++)
        begin
            if (m + parity_count(m) <= max_n)
                best = m;
        end
        return best;
    endfunction

    localparam int M_MAX = max_data_bits(MAX_CODE_BITS);

    // clamp the written register to a usable data width
    function automatic int effective_m(input logic [CFG_W-1:0] v);
        int m;
        m = int'(v);
        if (m < 1)
            m = 1;
        if (m > M_MAX)
            m = M_MAX;
        return m;
    endfunction

    // code length for a written register value
    function automatic logic [SYN_W-1:0] code_length(input logic [CFG_W-1:0] v);
        int m;
        m = effective_m(v);
        return SYN_W'(m + parity_count(m));
    endfunction

    // ones at positions 1..n
    function automatic logic [CODE_W-1:0] length_mask(input logic [SYN_W-1:0] n);
        logic [CODE_W-1:0] mask;
        for (int b = 0; b < CODE_W; b++)
            mask[b] = (b < int'(n));
        return mask;
    endfunction

    // floor(log2(p)) for p >= 1
    function automatic int log2_floor(input int p);
        int l;
        l = 0;
        for (int i = 1; i < 8; i++)
        begin
            if ((p >> i) != 0)
                l = i;
        end
        return l;
    endfunction

    // data bit index held at non-power-of-two position p
    function automatic int data_index(input int p);
        return p - log2_floor(p) - 2;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hamming_sec_encode_decode_core.sv =====
// ---------------------------------------------------------------------------
// hamming_sec_encode_decode_core
// Even-parity Hamming single-error-correcting encoder and decoder.
// ---------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a clock edge with start high and busy low.
//   busy stays low, so one transaction may be issued every cycle.
//   action selects encode (data_word in) or decode (code_word in).
//   Each result appears for exactly one cycle with result_valid high: the
//   input is registered, then the parity trees, correction and masking run
//   in one pass into the result register.
//   Throughput is one transaction per cycle; the receiver cannot stall.
//   cfg_valid/cfg_ready write data_bits (cfg_ready is always high); write it
//   only while no transaction is in flight. The code length and position
//   mask are derived at write time and held in registers.
//   Reset clears the pipeline valids and sets data_bits to 4 (n = 7).
//   Positions above the code length read as zero on code_out.
// ---------------------------------------------------------------------------
`default_nettype none

module hamming_sec_encode_decode_core
    import hsec_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              action,
    input  wire logic [DATA_W-1:0] data_word,
    input  wire logic [CODE_W-1:0] code_word,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data,
    output logic                   result_valid,
    output logic [CODE_W-1:0]      code_out,
    output logic [SYN_W-1:0]       syndrome,
    output logic                   error_found,
    output logic                   bit_flipped
);

    // configuration derived state
    logic [SYN_W-1:0]  len_reg;
    logic [CODE_W-1:0] mask_reg;

    // input stage
    logic              in_valid_reg;
    logic              action_reg;
    logic [DATA_W-1:0] data_reg;
    logic [CODE_W-1:0] code_in_reg;

    // result stage
    logic              out_valid_reg;
    logic [CODE_W-1:0] code_out_reg;
    logic [SYN_W-1:0]  syn_out_reg;
    logic              err_out_reg;
    logic              flip_out_reg;

    logic [CODE_W-1:0] code_out_next;
    logic [SYN_W-1:0]  syn_out_next;
    logic              err_out_next;
    logic              flip_out_next;

    logic [CODE_W-1:0] scattered;
    logic [CODE_W-1:0] enc_word;
    logic [CODE_W-1:0] dec_word;
    logic [SYN_W-1:0]  enc_par;
    logic [SYN_W-1:0]  dec_syn;
    logic [CODE_W-1:0] flip_mask;
    logic              dec_in_range;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration register, kept as code length and position mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= code_length(DATA_BITS_RESET);
            mask_reg <= length_mask(code_length(DATA_BITS_RESET));
        end
        else if (cfg_valid && cfg_ready)
        begin
            len_reg  <= code_length(cfg_data);
            mask_reg <= length_mask(code_length(cfg_data));
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            action_reg  <= action;
            data_reg    <= data_word;
            code_in_reg <= code_word;
        end
    end

    // place data bits at the non-power-of-two positions
    always_comb
    begin
        scattered = '0;
        for (int p = 1; p <= CODE_W; p++)
        begin
            if ((p & (p - 1)) != 0)
                scattered[p-1] = data_reg[data_index(p)];
        end
        scattered = scattered & mask_reg;
    end

    // parity trees for encode and decode
    always_comb
    begin
        dec_word = code_in_reg & mask_reg;
        enc_par  = '0;
        dec_syn  = '0;
        for (int i = 0; i < SYN_W; i++)
        begin
            for (int b = 0; b < CODE_W; b++)
            begin
                if ((((b + 1) >> i) & 1) != 0)
                begin
                    enc_par[i] = enc_par[i] ^ scattered[b];
                    dec_syn[i] = dec_syn[i] ^ dec_word[b];
                end
            end
        end
    end

    // encoded word with parity bits inserted
    always_comb
    begin
        enc_word = scattered;
        for (int i = 0; i < SYN_W; i++)
            enc_word[(1 << i) - 1] = enc_par[i];
        enc_word = enc_word & mask_reg;
    end

    // one-hot flip position from the syndrome
    always_comb
    begin
        for (int b = 0; b < CODE_W; b++)
            flip_mask[b] = (dec_syn == SYN_W'(b + 1));
        dec_in_range = (dec_syn != '0) && (dec_syn <= len_reg);
    end

    // result selection
    always_comb
    begin
        if (action_reg == ACT_DECODE)
        begin
            code_out_next = dec_in_range ? (dec_word ^ flip_mask) : dec_word;
            syn_out_next  = dec_syn;
            err_out_next  = (dec_syn != '0);
            flip_out_next = dec_in_range;
        end
        else
        begin
            code_out_next = enc_word;
            syn_out_next  = '0;
            err_out_next  = 1'b0;
            flip_out_next = 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            code_out_reg <= code_out_next;
            syn_out_reg  <= syn_out_next;
            err_out_reg  <= err_out_next;
            flip_out_reg <= flip_out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign code_out     = code_out_reg;
    assign syndrome     = syn_out_reg;
    assign error_found  = err_out_reg;
    assign bit_flipped  = flip_out_reg;

endmodule

`default_nettype wire

// ===== tb/hamming_sec_encode_decode_core_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// hamming_sec_encode_decode_core_tb
// Self-checking bench for the Hamming SEC encoder/decoder. Every accepted
// transaction is run through a local bit-level model of the code at the
// current data width, and each strobed result is compared field by field
// against the oldest queued prediction. Directed cases cover the width
// extremes and the corner cases, then random phases at several widths mix
// clean and single-error codewords with raw noise under bursty traffic.
// ---------------------------------------------------------------------------

module hamming_sec_encode_decode_core_tb;
    import hsec_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [SYN_W-1:0]  syn;
        logic              err;
        logic              flip;
    } sec_result_t;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PIPE_DEPTH  = 2;
    localparam int PHASE_ITEMS = 94;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              action;
    logic [DATA_W-1:0] data_word;
    logic [CODE_W-1:0] code_word;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;
    logic              result_valid;
    logic [CODE_W-1:0] code_out;
    logic [SYN_W-1:0]  syndrome;
    logic              error_found;
    logic              bit_flipped;

    // local copy of the data width register
    logic [CFG_W-1:0]  data_bits_q;
    sec_result_t       pending_results[$];
    int                mismatch_count = 0;
    int                cycle_count = 0;

    hamming_sec_encode_decode_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .data_word    (data_word),
        .code_word    (code_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .code_out     (code_out),
        .syndrome     (syndrome),
        .error_found  (error_found),
        .bit_flipped  (bit_flipped)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // smallest parity count covering m data bits
    function automatic int sec_parity_bits(input int m);
        int r;
        r = 0;
        while ((1 << r) < m + r + 1)
            r++;
        return r;
    endfunction

    // usable data width: zero reads as one, too large saturates
    function automatic int sec_data_width(input logic [CFG_W-1:0] v);
        int m;
        m = (v == '0) ? 1 : int'(v);
        while (m > 1 && m + sec_parity_bits(m) > MAX_CODE_BITS)
            m--;
        return m;
    endfunction

    function automatic int sec_code_length();
        int m;
        m = sec_data_width(data_bits_q);
        return m + sec_parity_bits(m);
    endfunction

    // xor of the positions of all set bits in 1..n
    function automatic logic [SYN_W-1:0] sec_syndrome(input logic [CODE_W-1:0] w,
                                                      input int n);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int p = 1; p <= n; p++)
            if (w[p-1])
                s = s ^ SYN_W'(p);
        return s;
    endfunction

    // expected result of one transaction at the current width
    function automatic sec_result_t hamming_predict(input logic act,
                                                    input logic [DATA_W-1:0] d,
                                                    input logic [CODE_W-1:0] c);
        sec_result_t      res;
        logic [CODE_W-1:0] cw;
        logic [SYN_W-1:0]  s;
        int               n;
        int               k;
        int               idx;
        res = '0;
        cw  = '0;
        n   = sec_code_length();
        if (act == ACT_ENCODE)
        begin
            // data bits into the non power-of-two positions
            k = 0;
            for (int p = 1; p <= n; p++)
            begin
                if ((p & (p - 1)) != 0)
                begin
                    cw[p-1] = d[k];
                    k++;
                end
            end
            // syndrome with zero parity gives the parity bits directly
            s = sec_syndrome(cw, n);
            for (int i = 0; i < SYN_W; i++)
                if (s[i])
                    cw[(1 << i) - 1] = 1'b1;
        end
        else
        begin
            for (int b = 0; b < CODE_W; b++)
                if (b < n)
                    cw[b] = c[b];
            s = sec_syndrome(cw, n);
            res.syn = s;
            if (s != '0)
            begin
                res.err = 1'b1;
                // syndrome past the code length is reported but not corrected
                if (int'(s) <= n)
                begin
                    idx = int'(s) - 1;
                    cw[idx] = ~cw[idx];
                    res.flip = 1'b1;
                end
            end
        end
        res.code = cw;
        return res;
    endfunction

    // result checker
    always @(posedge clk)
    begin : result_check
        sec_result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: code_out %h syndrome %0d", code_out, syndrome);
            end
            else
            begin
                want = pending_results.pop_front();
                if (code_out !== want.code || syndrome !== want.syn ||
                    error_found !== want.err || bit_flipped !== want.flip)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: code_out %h/%h syndrome %0d/%0d err %b/%b flip %b/%b",
                                 want.code, code_out, want.syn, syndrome,
                                 want.err, error_found, want.flip, bit_flipped);
                end
            end
        end
    end

    // one transaction, prediction queued at acceptance
    task automatic send_item(input logic act, input logic [DATA_W-1:0] d,
                             input logic [CODE_W-1:0] c);
        @(negedge clk);
        start     <= 1'b1;
        action    <= act;
        data_word <= d;
        code_word <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(hamming_predict(act, d, c));
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 1)
            @(posedge clk);
    endtask

    task automatic write_data_bits(input logic [CFG_W-1:0] v);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        data_bits_q = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random word with varied bit density
    function automatic logic [63:0] rand_bits64();
        logic [63:0] a;
        logic [63:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return a & b;
            1: return a | b;
            2: return '1;
            3: return '0;
            default: return a;
        endcase
    endfunction

    // reset width of four data bits
    task automatic test_reset_setting();
        send_item(ACT_ENCODE, '0, '0);
        send_item(ACT_ENCODE, {DATA_W{1'b1}}, '0);
        send_item(ACT_DECODE, '0, {CODE_W{1'b1}});
        send_item(ACT_DECODE, '0, CODE_W'(64'h6F));
        send_item(ACT_DECODE, {DATA_W{1'b1}}, '0);
    endtask

    // width extremes, saturation and out-of-range syndromes
    task automatic test_special_settings();
        logic [DATA_W-1:0] pattern;
        sec_result_t       enc;
        pattern = DATA_W'(64'hAAAA_AAAA_AAAA_AAAA);

        // zero data bits acts as one
        write_data_bits(6'd0);
        send_item(ACT_ENCODE, {DATA_W{1'b1}}, '0);
        send_item(ACT_DECODE, '0, CODE_W'(64'h5));

        // short code where syndromes can point past the end
        write_data_bits(6'd2);
        send_item(ACT_DECODE, '0, CODE_W'(64'hA));
        send_item(ACT_DECODE, '0, {{(CODE_W-4){1'b1}}, 4'hC});
        send_item(ACT_ENCODE, DATA_W'(64'h2), '0);

        // oversized width saturates to the full 63-bit code
        write_data_bits(6'd63);
        send_item(ACT_ENCODE, {DATA_W{1'b1}}, '0);
        send_item(ACT_DECODE, '0, {CODE_W{1'b1}});
        send_item(ACT_DECODE, '0, {1'b1, {(CODE_W-1){1'b0}}});
        send_item(ACT_ENCODE, '0, '0);

        // largest legal width
        write_data_bits(6'd57);
        send_item(ACT_ENCODE, pattern, '0);
        enc = hamming_predict(ACT_ENCODE, pattern, '0);
        send_item(ACT_DECODE, '0, enc.code ^ CODE_W'(64'h1));
    endtask

    // bursty random traffic at one width
    task automatic run_random_phase(input int count);
        int                burst;
        int                n;
        int                kind;
        int                pos;
        logic [DATA_W-1:0] d;
        logic [CODE_W-1:0] c;
        logic [CODE_W-1:0] low_mask;
        sec_result_t       enc;
        burst = $urandom_range(1, 40);
        for (int i = 0; i < count; i++)
        begin
            n        = sec_code_length();
            low_mask = CODE_W'((64'd1 << n) - 64'd1);
            kind     = $urandom_range(0, 9);
            d        = DATA_W'(rand_bits64());
            c        = CODE_W'(rand_bits64());
            if (kind <= 2)
                send_item(ACT_ENCODE, d, c);
            else if (kind <= 7)
            begin
                // valid codeword, sometimes with junk above n or one flipped bit
                enc = hamming_predict(ACT_ENCODE, d, '0);
                if ($urandom_range(0, 3) != 0)
                    c = '0;
                c = (c & ~low_mask) | enc.code;
                if ($urandom_range(0, 2) != 0)
                begin
                    pos = $urandom_range(0, n - 1);
                    c[pos] = ~c[pos];
                end
                send_item(ACT_DECODE, d, c);
            end
            else
                send_item(ACT_DECODE, d, c);

            burst--;
            if (burst == 0)
            begin
                if ($urandom_range(0, 30) == 0)
                    wait_drained();
                else if ($urandom_range(0, 4) != 0)
                    hold_off($urandom_range(1, 6));
                burst = $urandom_range(1, 40);
            end
        end
    endtask

    task automatic test_random_settings();
        logic [CFG_W-1:0] settings [10];
        settings[0] = 6'd1;
        settings[1] = 6'd57;
        settings[2] = 6'd63;
        settings[3] = 6'd0;
        settings[4] = 6'd2;
        settings[5] = 6'd26;
        settings[6] = 6'd27;
        settings[7] = 6'd4;
        settings[8] = CFG_W'($urandom_range(0, 63));
        settings[9] = CFG_W'($urandom_range(0, 63));
        for (int i = 0; i < 10; i++)
        begin
            write_data_bits(settings[i]);
            run_random_phase(PHASE_ITEMS);
        end
    endtask

    // main sequence
    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        action      = ACT_ENCODE;
        data_word   = '0;
        code_word   = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        data_bits_q = DATA_BITS_RESET;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_setting();
        test_special_settings();
        test_random_settings();

        wait_drained();
        repeat (PIPE_DEPTH * 4)
            @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
